>>> rtl/core/voxel_span_rle_decoder_defines.svh
// assertion macros shared by the voxel span decoder rtl
`ifndef VOXEL_SPAN_RLE_DECODER_DEFINES_SVH
`define VOXEL_SPAN_RLE_DECODER_DEFINES_SVH

// general clocked assertion, disabled while reset is high
`define VSRD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication form built on the general one
`define VSRD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   `VSRD_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

>>> rtl/core/vsrd_pkg.sv
// types and constants of the voxel span run-length decoder
package vsrd_pkg;

   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   localparam logic [7:0] HeightReset = 8'd255;

   localparam logic ReqSpanByte  = 1'b0;
   localparam logic ReqEmptyCol  = 1'b1;

   typedef enum logic [2:0] {
      PH_SKIP   = 3'd0,
      PH_COUNT  = 3'd1,
      PH_COLOR  = 3'd2,
      PH_NORMAL = 3'd3,
      PH_END    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] voxel_value;
      logic [7:0] run_length;
      logic       column_done;
      logic [7:0] top_color;
      logic       format_error;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/core/vsrd_front.sv
// span parser: classifies each request byte and builds the result it causes
module vsrd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           column_height,
   input  logic                 in_accept,
   input  logic                 in_type,
   input  logic [7:0]           in_byte,
   output logic                 out_push,
   output vsrd_pkg::result_type out_result
);

   vsrd_pkg::phase_type phase_ff, phase_in;
   logic [8:0] pos_ff, pos_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] span_ff, span_in;
   logic [7:0] high_ff, high_in;

   logic [9:0] pos_sum;
   logic       overrun;
   logic       end_bad;
   logic       end_done;

   assign pos_sum  = {1'b0, pos_ff} + {2'b00, in_byte};
   assign overrun  = pos_sum > {2'b00, column_height};
   assign end_bad  = in_byte != span_ff;
   assign end_done = pos_ff >= {1'b0, column_height};

   // next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (in_accept) begin
         if (in_type == vsrd_pkg::ReqEmptyCol) begin
            phase_in = vsrd_pkg::PH_SKIP;
         end else begin
            case (phase_ff)
               vsrd_pkg::PH_SKIP: begin
                  phase_in = overrun ? vsrd_pkg::PH_SKIP : vsrd_pkg::PH_COUNT;
               end
               vsrd_pkg::PH_COUNT: begin
                  if (overrun) begin
                     phase_in = vsrd_pkg::PH_SKIP;
                  end else if (in_byte == 8'd0) begin
                     phase_in = vsrd_pkg::PH_END;
                  end else begin
                     phase_in = vsrd_pkg::PH_COLOR;
                  end
               end
               vsrd_pkg::PH_COLOR: begin
                  phase_in = vsrd_pkg::PH_NORMAL;
               end
               vsrd_pkg::PH_NORMAL: begin
                  phase_in = (left_ff == 8'd0) ? vsrd_pkg::PH_END : vsrd_pkg::PH_COLOR;
               end
               vsrd_pkg::PH_END: begin
                  phase_in = vsrd_pkg::PH_SKIP;
               end
               default: begin
                  phase_in = vsrd_pkg::PH_SKIP;
               end
            endcase
         end
      end
   end

   // column datapath and result
   always_comb begin
      pos_in     = pos_ff;
      left_in    = left_ff;
      span_in    = span_ff;
      high_in    = high_ff;
      out_push   = 1'b0;
      out_result = '0;
      if (in_accept) begin
         if (in_type == vsrd_pkg::ReqEmptyCol) begin
            pos_in                 = '0;
            left_in                = '0;
            span_in                = '0;
            high_in                = '0;
            out_push               = 1'b1;
            out_result.column_done = 1'b1;
         end else begin
            case (phase_ff)
               vsrd_pkg::PH_SKIP, vsrd_pkg::PH_COUNT: begin
                  if (overrun) begin
                     pos_in                  = '0;
                     left_in                 = '0;
                     span_in                 = '0;
                     high_in                 = '0;
                     out_push                = 1'b1;
                     out_result.column_done  = 1'b1;
                     out_result.format_error = 1'b1;
                  end else if (phase_ff == vsrd_pkg::PH_SKIP) begin
                     pos_in                = pos_sum[8:0];
                     // a zero skip gives no result
                     out_push              = in_byte != 8'd0;
                     out_result.run_length = in_byte;
                  end else begin
                     span_in = in_byte;
                     left_in = in_byte;
                  end
               end
               vsrd_pkg::PH_COLOR: begin
                  if (in_byte != 8'd0) begin
                     high_in = in_byte;
                  end
                  pos_in                 = pos_ff + 9'd1;
                  left_in                = left_ff - 8'd1;
                  out_push               = 1'b1;
                  out_result.voxel_value = in_byte;
                  out_result.run_length  = 8'd1;
               end
               vsrd_pkg::PH_NORMAL: begin
                  // normals are dropped
               end
               vsrd_pkg::PH_END: begin
                  if (end_bad || end_done) begin
                     pos_in                  = '0;
                     left_in                 = '0;
                     span_in                 = '0;
                     high_in                 = '0;
                     out_push                = 1'b1;
                     out_result.column_done  = 1'b1;
                     out_result.format_error = end_bad;
                     out_result.top_color    = end_bad ? 8'd0 : high_ff;
                  end
               end
               default: begin
                  pos_in  = '0;
                  left_in = '0;
                  span_in = '0;
                  high_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= vsrd_pkg::PH_SKIP;
         pos_ff   <= '0;
         left_ff  <= '0;
         span_ff  <= '0;
         high_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         left_ff  <= left_in;
         span_ff  <= span_in;
         high_ff  <= high_in;
      end
   end

endmodule

>>> rtl/core/vsrd_queue.sv
// short result queue between parser and output stage
module vsrd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  vsrd_pkg::result_type       push_data,
   input  logic                       pop,
   output vsrd_pkg::result_type       head_data,
   output vsrd_pkg::queue_status_type status
);

   vsrd_pkg::result_type mem_ff [vsrd_pkg::QueueDepth];

   logic [vsrd_pkg::QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vsrd_pkg::QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vsrd_pkg::QCntW-1:0] count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign status.full  = count_ff == vsrd_pkg::QCntW'(vsrd_pkg::QueueDepth);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/vsrd_back.sv
// output stage: holds one result on the response channel
module vsrd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  vsrd_pkg::result_type       head_data,
   input  vsrd_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   logic                 valid_ff, valid_in;
   vsrd_pkg::result_type hold_ff, hold_in;

   // refill when the stage is empty or its result goes out this cycle
   assign pop = (!valid_ff || rsp_tready) && !status.empty;

   always_comb begin
      valid_in = valid_ff;
      hold_in  = hold_ff;
      if (pop) begin
         valid_in = 1'b1;
         hold_in  = head_data;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {hold_ff.top_color, hold_ff.run_length, hold_ff.voxel_value};
   assign rsp_tlast  = hold_ff.column_done;
   assign rsp_tuser  = hold_ff.format_error;

endmodule

>>> rtl/core/voxel_span_rle_decoder.sv
// voxel span run-length decoder top level
//
//   channel   dir  group          contents
//   request   in   req_t*         tdata: data_byte; tuser: req_type
//   response  out  rsp_t*         tdata: voxel_value, run_length, top_color;
//                                 tlast: column_done; tuser: format_error
//   csr       in   csr_wr_*       column_height
//
// one request per cycle while the queue is not full; the parser acts on a byte
// in the cycle it is taken; a result passes the queue and the output register
// on its way to rsp_tvalid; a four-entry queue and the output register decouple
// both sides; req_tready drops only when the queue is full
// reset (synchronous) sets column_height to 255 and the parser to a new column
`include "voxel_span_rle_decoder_defines.svh"

module voxel_span_rle_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] voxel_value, [15:8] run_length, [23:16] top_color
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] format_error
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic [7:0] height_ff, height_in;

   logic                       req_accept;
   logic                       push;
   vsrd_pkg::result_type       push_data;
   vsrd_pkg::result_type       head_data;
   vsrd_pkg::queue_status_type q_status;
   logic                       pop;

   assign height_in = csr_wr_en ? csr_wr_data : height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= vsrd_pkg::HeightReset;
      end else begin
         height_ff <= height_in;
      end
   end

   assign req_tready = !q_status.full;
   assign req_accept = req_tvalid && req_tready;

   vsrd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .column_height (height_ff),
      .in_accept     (req_accept),
      .in_type       (req_tuser),
      .in_byte       (req_tdata),
      .out_push      (push),
      .out_result    (push_data)
   );

   vsrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   vsrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .status     (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `VSRD_ASSERT_IMP(a_err_is_done, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && rsp_tdata == 24'd0, "error result must end the column with zero payload")
   `VSRD_ASSERT_IMP(a_done_no_run, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[15:0] == 16'd0, "done result must carry no run")
   `VSRD_ASSERT_IMP(a_run_nonzero, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[15:8] != 8'd0 && rsp_tdata[23:16] == 8'd0 && !rsp_tuser, "run result must have a length and no column fields")
   `VSRD_ASSERT(a_marker_out, clock, reset, (req_accept && req_tuser == vsrd_pkg::ReqEmptyCol) |-> ##2 rsp_tvalid, "empty column request must reach the response side")

endmodule

>>> dv/testbench.sv
// self-checking testbench for the voxel span run-length decoder
`timescale 1ns / 100ps

module testbench;

   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 8;
   localparam int TotalItems  = 1150;

   typedef enum int {
      FLAW_NONE,
      FLAW_END_BYTE,
      FLAW_SKIP_OVER,
      FLAW_COUNT_OVER,
      FLAW_ABORT,
      FLAW_NOISE
   } flaw_kind_type;

   typedef struct packed {
      logic       req_kind;
      logic [7:0] data_byte;
   } span_req_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   voxel_span_rle_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   span_req_type         pending_bytes[$];
   vsrd_pkg::result_type col_results[$];
   int                   items_queued = 0;
   int                   items_taken  = 0;
   int                   failures     = 0;

   // decoder state as the testbench sees it
   vsrd_pkg::phase_type col_phase  = vsrd_pkg::PH_SKIP;
   logic [8:0]          col_pos    = '0;
   logic [7:0]          col_left   = '0;
   logic [7:0]          col_span   = '0;
   logic [7:0]          col_top    = '0;
   logic [7:0]          col_height = vsrd_pkg::HeightReset;

   // column position the stimulus generator assumes
   int gen_pos = 0;

   function automatic void restart_column();
      col_phase = vsrd_pkg::PH_SKIP;
      col_pos   = '0;
      col_left  = '0;
      col_span  = '0;
      col_top   = '0;
   endfunction

   function automatic bit decode_span(input logic kind, input logic [7:0] b,
                                      output vsrd_pkg::result_type r);
      r = '0;
      if (kind == vsrd_pkg::ReqEmptyCol) begin
         restart_column();
         r.column_done = 1'b1;
         return 1'b1;
      end
      case (col_phase)
         vsrd_pkg::PH_SKIP, vsrd_pkg::PH_COUNT: begin
            if (int'(col_pos) + int'(b) > int'(col_height)) begin
               restart_column();
               r.column_done  = 1'b1;
               r.format_error = 1'b1;
               return 1'b1;
            end
            if (col_phase == vsrd_pkg::PH_SKIP) begin
               col_pos   = col_pos + 9'(b);
               col_phase = vsrd_pkg::PH_COUNT;
               r.run_length = b;
               return b != 8'd0;
            end
            col_span  = b;
            col_left  = b;
            col_phase = (b == 8'd0) ? vsrd_pkg::PH_END : vsrd_pkg::PH_COLOR;
            return 1'b0;
         end
         vsrd_pkg::PH_COLOR: begin
            if (b != 8'd0) col_top = b;
            col_pos   = col_pos + 9'd1;
            col_left  = col_left - 8'd1;
            col_phase = vsrd_pkg::PH_NORMAL;
            r.voxel_value = b;
            r.run_length  = 8'd1;
            return 1'b1;
         end
         vsrd_pkg::PH_NORMAL: begin
            col_phase = (col_left == 8'd0) ? vsrd_pkg::PH_END : vsrd_pkg::PH_COLOR;
            return 1'b0;
         end
         vsrd_pkg::PH_END: begin
            if (b != col_span) begin
               restart_column();
               r.column_done  = 1'b1;
               r.format_error = 1'b1;
               return 1'b1;
            end
            if (col_pos >= 9'(col_height)) begin
               r.column_done = 1'b1;
               r.top_color   = col_top;
               restart_column();
               return 1'b1;
            end
            col_phase = vsrd_pkg::PH_SKIP;
            return 1'b0;
         end
         default: begin
            restart_column();
            return 1'b0;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // request driver: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_requests
      span_req_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_req = pending_bytes.pop_front();
            req_tuser  <= next_req.req_kind;
            req_tdata  <= next_req.data_byte;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response stall pattern: modes of random duration
   int         stall_mode = 0;
   int         stall_span = 0;
   logic [2:0] stall_tick = '0;

   always @(posedge clock) begin
      stall_tick <= stall_tick + 3'd1;
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 200);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_tick < 3'd5);
      endcase
   end

   // predict on each accepted request, check each accepted response
   always @(posedge clock) begin : scoreboard
      vsrd_pkg::result_type predicted;
      vsrd_pkg::result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            items_taken++;
            if (decode_span(req_tuser, req_tdata, predicted)) col_results.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (col_results.size() == 0) begin
               $error("unexpected response: tdata %h, tlast %b, tuser %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               failures++;
            end else begin
               want = col_results.pop_front();
               check_field("voxel_value", want.voxel_value, rsp_tdata[7:0]);
               check_field("run_length", want.run_length, rsp_tdata[15:8]);
               check_field("column_done", 8'(want.column_done), 8'(rsp_tlast));
               check_field("top_color", want.top_color, rsp_tdata[23:16]);
               check_field("format_error", 8'(want.format_error), 8'(rsp_tuser));
            end
         end
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_item(input logic kind, input logic [7:0] b);
      span_req_type r;
      r.req_kind  = kind;
      r.data_byte = b;
      pending_bytes.push_back(r);
      items_queued++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_item(vsrd_pkg::ReqSpanByte, b);
   endtask

   task automatic wait_idle();
      while (items_taken != items_queued || col_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_height(input logic [7:0] h);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= h;
      col_height = h;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one span from the generator's column position; hold keeps the column open
   task automatic add_span(input int h, input flaw_kind_type flaw, input bit hold,
                           output bit ended);
      int            rem;
      int            cnt;
      int            skip;
      flaw_kind_type kind;
      rem   = h - gen_pos;
      kind  = flaw;
      ended = 1'b1;
      if (rem < 0) begin
         // already past the height: any skip count overruns
         push_byte(8'($urandom_range(0, 255)));
         gen_pos = 0;
         return;
      end
      if (kind == FLAW_SKIP_OVER && rem < 255) begin
         push_byte(8'($urandom_range(rem + 1, 255)));
         gen_pos = 0;
         return;
      end
      if (kind == FLAW_NOISE) begin
         repeat ($urandom_range(1, 12))
            push_item(($urandom_range(0, 7) == 0) ? vsrd_pkg::ReqEmptyCol
                                                  : vsrd_pkg::ReqSpanByte,
                      8'($urandom_range(0, 255)));
         push_item(vsrd_pkg::ReqEmptyCol, 8'($urandom_range(0, 255)));
         gen_pos = 0;
         return;
      end
      if (hold && rem < 1) hold = 1'b0;
      if (hold) begin
         cnt  = $urandom_range(0, (rem - 1 < 4) ? rem - 1 : 4);
         skip = $urandom_range(0, rem - 1 - cnt);
      end else begin
         cnt  = $urandom_range(0, (rem < 4) ? rem : 4);
         skip = ($urandom_range(0, 2) == 0) ? rem - cnt : $urandom_range(0, rem - cnt);
      end
      push_byte(8'(skip));
      if (kind == FLAW_COUNT_OVER) begin
         if (rem - skip < 255) begin
            push_byte(8'($urandom_range(rem - skip + 1, 255)));
            gen_pos = 0;
            return;
         end
         kind = FLAW_END_BYTE;
      end
      push_byte(8'(cnt));
      repeat (cnt) begin
         push_byte(8'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255)));
         push_byte(8'($urandom_range(0, 255)));
      end
      if (kind == FLAW_ABORT) begin
         push_item(vsrd_pkg::ReqEmptyCol, 8'($urandom_range(0, 255)));
         gen_pos = 0;
         return;
      end
      if (kind == FLAW_END_BYTE) begin
         push_byte(8'((cnt + $urandom_range(1, 255)) % 256));
         gen_pos = 0;
         return;
      end
      push_byte(8'(cnt));
      gen_pos = gen_pos + skip + cnt;
      ended = (gen_pos >= h);
      if (ended) gen_pos = 0;
   endtask

   task automatic add_column(input int h, input flaw_kind_type flaw);
      bit ended;
      int spans;
      if (gen_pos == 0 && $urandom_range(0, 9) == 0) begin
         push_item(vsrd_pkg::ReqEmptyCol, 8'($urandom_range(0, 255)));
         return;
      end
      ended = 1'b0;
      spans = 0;
      while (!ended) begin
         spans++;
         add_span(h, (flaw != FLAW_NONE && ($urandom_range(0, 2) == 0 || spans >= 4))
                     ? flaw : FLAW_NONE, 1'b0, ended);
      end
   endtask

   initial begin : stimulus
      int            phase_no;
      int            phase_end;
      int            h;
      bit            ended;
      flaw_kind_type flaw;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed requests at the reset height
      push_item(vsrd_pkg::ReqEmptyCol, 8'hff);
      push_byte(8'd0);   push_byte(8'd0);   push_byte(8'd0);
      push_byte(8'd253); push_byte(8'd2);
      push_byte(8'hff);  push_byte(8'h00);
      push_byte(8'h00);  push_byte(8'hff);
      push_byte(8'd2);
      push_byte(8'd0);   push_byte(8'd0);   push_byte(8'd9);
      push_byte(8'd200); push_byte(8'd56);
      push_byte(8'd100); push_byte(8'd0);   push_byte(8'd0);   push_byte(8'd156);
      push_byte(8'd5);   push_byte(8'd1);   push_byte(8'h11);
      push_item(vsrd_pkg::ReqEmptyCol, 8'h00);
      wait_idle();

      phase_no = 0;
      while (items_queued < TotalItems) begin
         case (phase_no)
            0: h = 1;
            1: h = 0;
            2: h = 255;
            default: begin
               case ($urandom_range(0, 15))
                  0, 1:    h = 255;
                  2, 3:    h = 1;
                  4:       h = 0;
                  default: h = $urandom_range(2, 24);
               endcase
            end
         endcase
         write_height(8'(h));
         phase_end = items_queued + $urandom_range(60, 140);
         while (items_queued < phase_end && items_queued < TotalItems) begin
            flaw = ($urandom_range(0, 3) != 0) ? FLAW_NONE
                   : flaw_kind_type'($urandom_range(FLAW_END_BYTE, FLAW_NOISE));
            add_column(h, flaw);
         end
         // leave a column open across the height change now and then
         if ($urandom_range(0, 1) == 1) add_span(h, FLAW_NONE, 1'b1, ended);
         wait_idle();
         phase_no++;
      end

      wait_idle();
      repeat (2 * DrainCycles) @(posedge clock);
      if (failures == 0 && col_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
